// ----- rtl/core/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared beat types, operation codes and cell commands for the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

    // operation codes carried in the request mode field
    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_BACK   = 2'd3;

    // per-cell commands broadcast along the chain
    localparam logic [1:0] CELL_HOLD        = 2'd0;
    localparam logic [1:0] CELL_SHIFT_BACK  = 2'd1;
    localparam logic [1:0] CELL_SHIFT_FRONT = 2'd2;
    localparam logic [1:0] CELL_WRITE_TAIL  = 2'd3;

    localparam int unsigned ENTRY_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ENTRY_W-1:0] entry;
    } req_beat_t;

    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] front_entry;
        logic [ENTRY_W-1:0] back_entry;
        logic [COUNT_W-1:0] fill_count;
        logic               is_empty;
        logic               is_full;
    } rsp_beat_t;

    typedef struct packed {
        logic [1:0] op;
        logic       ok;
    } cell_cmd_t;

endpackage

// ----- rtl/core/dq_cell.sv -----
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the deque chain; shifts toward either neighbor or loads the tail.
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CW         = 5
) (
    input  logic                  clk,
    input  dq_pkg::cell_cmd_t     cmd,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] entry,
    input  logic [DATA_WIDTH-1:0] from_front,
    input  logic [DATA_WIDTH-1:0] from_back,
    output logic [DATA_WIDTH-1:0] data
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            CELL_HOLD:        data_next = data_reg;
            CELL_SHIFT_BACK:  data_next = from_front;
            CELL_SHIFT_FRONT: data_next = from_back;
            CELL_WRITE_TAIL:
            begin
                if (count == CW'(INDEX))
                begin
                    data_next = entry;
                end
            end
            default:          data_next = data_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Decodes the requested operation against the fill count and steers the chain.
// ----------------------------------------------------------------------------
module dq_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CW    = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        mode,
    output dq_pkg::cell_cmd_t cmd,
    output logic [CW-1:0]     count
);
    import dq_pkg::*;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          is_full;
    logic          is_empty;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        cmd.op     = CELL_HOLD;
        cmd.ok     = 1'b0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (mode)
                MODE_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        cmd.op     = CELL_SHIFT_BACK;
                        cmd.ok     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (!is_full)
                    begin
                        cmd.op     = CELL_WRITE_TAIL;
                        cmd.ok     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        cmd.op     = CELL_SHIFT_FRONT;
                        cmd.ok     = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                MODE_POP_BACK:
                begin
                    // tail simply drops off, cells keep their words
                    if (!is_empty)
                    begin
                        cmd.ok     = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    cmd.op = CELL_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of data words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation per beat:
//   push front, push back, pop front or pop back. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one beat per request, in order, with the
//   ok flag, front and back words, fill count and empty / full flags as they
//   stand after the operation. A refused push (full) or pop (empty) leaves
//   the contents untouched and reports ok = 0.
// Throughput: one request per cycle while rsp_stall does not hold the response
//   register; the cell row updates in the accept cycle, busy_reg marks the
//   result pending and the response register samples the row when it loads.
// Cell 0 is always the front. Push front shifts the whole row back by one,
//   pop front shifts it forward, push back loads the cell at the fill count,
//   pop back only lowers the count.
// Reset: clears the fill count and the handshake flags; cell words are not
//   reset and are never shown until written.
// Receiver stall: the response register holds; once a response is pending
//   behind it, req_stall rises until the response register drains.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dq_pkg::req_beat_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dq_pkg::rsp_beat_t rsp
);
    import dq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = $clog2(DEPTH);

    cell_cmd_t             cmd;
    logic [CW-1:0]         count;
    logic [DATA_WIDTH-1:0] entry;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  accept;
    logic                  load;

    // response handshake state
    logic                  busy_reg;
    logic                  busy_next;
    logic                  ok_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_beat_t             rsp_reg;
    rsp_beat_t             rsp_next;

    // a pending result moves to the response register whenever it is free
    assign load      = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = busy_reg && !load;
    assign accept    = req_valid && !req_stall;
    assign entry     = DATA_WIDTH'(req.entry);

    dq_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .mode   (req.mode),
        .cmd    (cmd),
        .count  (count)
    );

    // the row of cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] from_front;
        logic [DATA_WIDTH-1:0] from_back;

        if (i == 0)
        begin : g_first
            assign from_front = entry;
        end
        else
        begin : g_mid_front
            assign from_front = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign from_back = cell_data[i];
        end
        else
        begin : g_mid_back
            assign from_back = cell_data[i+1];
        end

        dq_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count),
            .entry      (entry),
            .from_front (from_front),
            .from_back  (from_back),
            .data       (cell_data[i])
        );
    end

    // response assembled from the row as it stands after the operation
    logic [AW-1:0] back_index;
    logic          row_empty;

    assign back_index = AW'(count - CW'(1));
    assign row_empty  = (count == '0);

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg;
        busy_next            = busy_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load)
        begin
            rsp_next.ok          = ok_reg;
            rsp_next.front_entry = row_empty ? '0 : ENTRY_W'(cell_data[0]);
            rsp_next.back_entry  = row_empty ? '0 : ENTRY_W'(cell_data[back_index]);
            rsp_next.fill_count  = COUNT_W'(count);
            rsp_next.is_empty    = row_empty;
            rsp_next.is_full     = (count == CW'(DEPTH));
            rsp_valid_next       = 1'b1;
            busy_next            = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload beats, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            ok_reg <= cmd.ok;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
